// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// The property must hold at every rising clock edge outside reset.
`define ASSERT_CHECK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// The expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CHECK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ===== hdl/ltc_pkg.sv =====
// ----------------------------------------------------------------------------
// ltc_pkg
// Types and constants of the reader token classifier.
// ----------------------------------------------------------------------------
package ltc_pkg;

  localparam int unsigned CharWidthDef = 21;
  localparam int unsigned RadixWidth   = 6;
  localparam int unsigned ApbAddrWidth = 3;
  localparam int unsigned ApbDataWidth = 32;

  localparam logic [RadixWidth-1:0] RadixReset = 6'd10;

  // Register byte addresses, upper bits only (word aligned).
  localparam logic RegRadix = 1'b0;

  // Seven-bit character codes.
  localparam logic [6:0] ChZero         = 7'h30;
  localparam logic [6:0] ChNine         = 7'h39;
  localparam logic [6:0] ChLowA         = 7'h61;
  localparam logic [6:0] ChLowZ         = 7'h7A;
  localparam logic [6:0] ChUpA          = 7'h41;
  localparam logic [6:0] ChUpZ          = 7'h5A;
  localparam logic [6:0] ChPlus         = 7'h2B;
  localparam logic [6:0] ChMinus        = 7'h2D;
  localparam logic [6:0] ChDot          = 7'h2E;
  localparam logic [6:0] ChSlash        = 7'h2F;
  localparam logic [6:0] ChCaret        = 7'h5E;
  localparam logic [6:0] ChUnder        = 7'h5F;
  localparam logic [6:0] ChColon        = 7'h3A;
  localparam logic [6:0] ChFirstGraphic = 7'h21;
  localparam logic [6:0] ChLastGraphic  = 7'h7E;
  localparam logic [6:0] ChCaseBit      = 7'h20;
  localparam logic [6:0] ChLowD         = 7'h64;
  localparam logic [6:0] ChLowE         = 7'h65;
  localparam logic [6:0] ChLowF         = 7'h66;
  localparam logic [6:0] ChLowL         = 7'h6C;
  localparam logic [6:0] ChLowS         = 7'h73;
  // Offsets that turn a letter code into its digit value (10 and up).
  localparam logic [6:0] LowLetterBias  = 7'h57;
  localparam logic [6:0] UpLetterBias   = 7'h37;

  typedef enum logic [2:0] {
    KIND_INT   = 3'd0,
    KIND_DEC   = 3'd1,
    KIND_RATIO = 3'd2,
    KIND_FLOAT = 3'd3,
    KIND_DOT   = 3'd4,
    KIND_SYM   = 3'd5,
    KIND_POT   = 3'd6,
    KIND_ERR   = 3'd7
  } kind_e;

  typedef enum logic [4:0] {
    POS_FIRST   = 5'd0,
    POS_DOT1    = 5'd1,
    POS_DOT2    = 5'd2,
    POS_DIGIT1  = 5'd3,
    POS_DIGIT2  = 5'd4,
    POS_DIGIT3  = 5'd5,
    POS_RATIO1  = 5'd6,
    POS_RATIO2  = 5'd7,
    POS_FLOAT1  = 5'd8,
    POS_FLOAT3  = 5'd9,
    POS_FLOAT4  = 5'd10,
    POS_FLOAT5  = 5'd11,
    POS_FLOAT6  = 5'd12,
    POS_EXP1    = 5'd13,
    POS_EXP2    = 5'd14,
    POS_EXP3    = 5'd15,
    POS_POT     = 5'd16,
    POS_POTSIGN = 5'd17,
    POS_POTMARK = 5'd18
  } pos_e;

  // One automaton move: either a verdict or the next position.
  typedef struct packed {
    logic  done;
    kind_e kind;
    pos_e  pos;
  } step_t;

endpackage

// ===== hdl/ltc_if.sv =====
// ----------------------------------------------------------------------------
// ltc_if
// Valid/ready channels of the token classifier: characters in, kinds out.
// ----------------------------------------------------------------------------
interface ltc_char_if #(
  parameter int unsigned CHAR_WIDTH = ltc_pkg::CharWidthDef
);
  logic                  valid;
  logic                  ready;
  logic [CHAR_WIDTH-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface ltc_kind_if;
  logic              valid;
  logic              ready;
  ltc_pkg::kind_e    token_kind;

  modport source (output valid, output token_kind, input ready);
  modport sink   (input valid, input token_kind, output ready);
endinterface

// ===== hdl/lisp_token_classifier.sv =====
// ----------------------------------------------------------------------------
// lisp_token_classifier
// Classifies a reader token, fed one character per transfer, as integer,
// decimal, ratio, float, dot, symbol, potential number or error.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Payload              Transfer when
//   char_i    in    char_code            valid && ready
//   kind_o    out   token_kind           valid && ready
//   APB       in    read_radix (addr 0)  psel && penable && pwrite && pready
//
// Each character passes first through the input register and then through the
// automaton into the result register. One character is taken per cycle; a
// terminator only stalls while an earlier kind still waits in the result
// register and the sink holds ready low, since the result register is a single
// stage. Non-terminator characters never wait on the output side.
// Reset clears the automaton, the held verdict and both valid flags, and sets
// the radix to ten.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lisp_token_classifier #(
  parameter int unsigned CHAR_WIDTH = ltc_pkg::CharWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ltc_pkg::ApbAddrWidth-1:0]  paddr,
  input  logic [ltc_pkg::ApbDataWidth-1:0]  pwdata,
  output logic [ltc_pkg::ApbDataWidth-1:0]  prdata,
  output logic                              pready,
  ltc_char_if.sink                          char_i,
  ltc_kind_if.source                        kind_o
);

  // --------------------------------------------------------------------------
  // Configuration register. The only register sits at byte address zero; any
  // address with bit two set lies beyond it and is ignored.
  // --------------------------------------------------------------------------
  logic [ltc_pkg::RadixWidth-1:0] radix_q;
  logic                           radix_sel;

  assign pready    = 1'b1;
  assign radix_sel = (paddr[2] == ltc_pkg::RegRadix);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= ltc_pkg::RadixReset;
    end else if (psel && penable && pwrite && pready && radix_sel) begin
      radix_q <= pwdata[ltc_pkg::RadixWidth-1:0];
    end
  end

  assign prdata = radix_sel
                ? {{(ltc_pkg::ApbDataWidth-ltc_pkg::RadixWidth){1'b0}}, radix_q}
                : '0;

  // --------------------------------------------------------------------------
  // Input register. A character moves on (fire) unless it is a terminator and
  // the result register is still full.
  // --------------------------------------------------------------------------
  logic [CHAR_WIDTH-1:0] char_q;
  logic                  char_vld_q;
  logic                  char_term;
  logic                  fire;
  logic                  out_vld_q;
  ltc_pkg::kind_e        out_kind_q;

  assign char_term   = (char_q == '0);
  assign fire        = char_vld_q && (!char_term || !out_vld_q || kind_o.ready);
  assign char_i.ready = !char_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_vld_q <= 1'b0;
    end else if (char_i.ready) begin
      char_vld_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.ready && char_i.valid) begin
      char_q <= char_i.char_code;
    end
  end

  // --------------------------------------------------------------------------
  // Character classes. Only seven-bit codes take part in the automaton; codes
  // of 0x80 and above fall out as symbol before the automaton is consulted.
  // --------------------------------------------------------------------------
  logic                            is_ascii;
  logic [6:0]                      ch;
  logic [6:0]                      ch_fold;
  logic                            is_dec;
  logic                            is_lower;
  logic                            is_upper;
  logic                            is_alpha;
  logic                            is_sign;
  logic                            is_dot;
  logic                            is_slash;
  logic                            is_expo;
  logic                            is_rdig;
  logic                            is_potc;
  logic                            in_set;
  logic [6:0]                      dval_wide;

  assign is_ascii = (char_q[CHAR_WIDTH-1:7] == '0);
  assign ch       = char_q[6:0];
  assign ch_fold  = ch | ltc_pkg::ChCaseBit;

  assign is_dec   = is_ascii && (ch >= ltc_pkg::ChZero) && (ch <= ltc_pkg::ChNine);
  assign is_lower = is_ascii && (ch >= ltc_pkg::ChLowA) && (ch <= ltc_pkg::ChLowZ);
  assign is_upper = is_ascii && (ch >= ltc_pkg::ChUpA) && (ch <= ltc_pkg::ChUpZ);
  assign is_alpha = is_lower || is_upper;
  assign is_sign  = is_ascii && ((ch == ltc_pkg::ChPlus) || (ch == ltc_pkg::ChMinus));
  assign is_dot   = is_ascii && (ch == ltc_pkg::ChDot);
  assign is_slash = is_ascii && (ch == ltc_pkg::ChSlash);
  assign is_expo  = is_alpha && ((ch_fold == ltc_pkg::ChLowD) || (ch_fold == ltc_pkg::ChLowE)
                              || (ch_fold == ltc_pkg::ChLowF) || (ch_fold == ltc_pkg::ChLowS)
                              || (ch_fold == ltc_pkg::ChLowL));

  // Digit value of a decimal digit or a letter, compared against the radix.
  always_comb begin
    if (is_lower) begin
      dval_wide = ch - ltc_pkg::LowLetterBias;
    end else if (is_upper) begin
      dval_wide = ch - ltc_pkg::UpLetterBias;
    end else begin
      dval_wide = ch - ltc_pkg::ChZero;
    end
  end

  assign is_rdig = (is_dec || is_alpha)
                && (dval_wide[ltc_pkg::RadixWidth-1:0] < radix_q);
  assign is_potc = is_rdig || is_sign || is_dot || is_slash || is_expo
                || (is_ascii && ((ch == ltc_pkg::ChCaret) || (ch == ltc_pkg::ChUnder)));
  assign in_set  = is_ascii && (ch >= ltc_pkg::ChFirstGraphic)
                && (ch <= ltc_pkg::ChLastGraphic) && (ch != ltc_pkg::ChColon);

  // --------------------------------------------------------------------------
  // Token state.
  // --------------------------------------------------------------------------
  ltc_pkg::pos_e  pos_q;
  logic           first_q;
  logic           saw_q;
  logic           dall_q;
  logic           held_q;
  ltc_pkg::kind_e hkind_q;

  logic           in_first;
  logic           first_n;
  ltc_pkg::kind_e kind_pot_sym;
  ltc_pkg::kind_e kind_float;
  ltc_pkg::step_t as_sym;
  ltc_pkg::step_t as_sign;
  ltc_pkg::step_t as_mark;
  ltc_pkg::step_t step;
  ltc_pkg::kind_e result_kind;

  assign in_first = (pos_q == ltc_pkg::POS_FIRST);
  // On the first character the "may begin a number" flag is decided now and
  // is already in force for the fallback moves below.
  assign first_n  = in_first
                  ? (is_rdig || is_sign || is_dot
                     || (is_ascii && ((ch == ltc_pkg::ChCaret) || (ch == ltc_pkg::ChUnder))))
                  : first_q;

  assign kind_pot_sym = saw_q ? ltc_pkg::KIND_POT : ltc_pkg::KIND_SYM;
  assign kind_float   = dall_q ? ltc_pkg::KIND_FLOAT : kind_pot_sym;

  // Fallback moves once a character breaks the number grammar: the token may
  // still be a potential number, otherwise it is a symbol.
  always_comb begin
    as_sym  = '{done: 1'b1, kind: ltc_pkg::KIND_SYM, pos: ltc_pkg::POS_FIRST};
    as_sign = as_sym;
    as_mark = as_sym;

    if (first_n) begin
      if (char_term) begin
        as_sym.kind = kind_pot_sym;
      end else if (is_sign) begin
        as_sym = '{done: 1'b0, kind: ltc_pkg::KIND_SYM, pos: ltc_pkg::POS_POTSIGN};
      end else if (is_rdig) begin
        as_sym = '{done: 1'b0, kind: ltc_pkg::KIND_SYM, pos: ltc_pkg::POS_POT};
      end else if (is_alpha) begin
        as_sym = '{done: 1'b0, kind: ltc_pkg::KIND_SYM, pos: ltc_pkg::POS_POTMARK};
      end else if (is_potc) begin
        as_sym = '{done: 1'b0, kind: ltc_pkg::KIND_SYM, pos: ltc_pkg::POS_POT};
      end

      // After a sign the end of the token is a symbol outright.
      if (!char_term) begin
        as_sign = as_sym;
      end

      // After an exponent marker a second letter that is not a radix digit ends the chance of a number.
      if (char_term) begin
        as_mark.kind = kind_pot_sym;
      end else if (is_rdig) begin
        as_mark = '{done: 1'b0, kind: ltc_pkg::KIND_SYM, pos: ltc_pkg::POS_POT};
      end else if (is_alpha) begin
        as_mark = '{done: 1'b1, kind: ltc_pkg::KIND_SYM, pos: ltc_pkg::POS_FIRST};
      end else if (is_sign) begin
        as_mark = '{done: 1'b0, kind: ltc_pkg::KIND_SYM, pos: ltc_pkg::POS_POTSIGN};
      end else if (is_potc) begin
        as_mark = '{done: 1'b0, kind: ltc_pkg::KIND_SYM, pos: ltc_pkg::POS_POT};
      end
    end
  end

  // Main automaton move for the character in the input register.
  always_comb begin
    ltc_pkg::step_t go;
    ltc_pkg::step_t verdict;

    go      = '{done: 1'b0, kind: ltc_pkg::KIND_INT, pos: ltc_pkg::POS_FIRST};
    verdict = '{done: 1'b1, kind: ltc_pkg::KIND_INT, pos: ltc_pkg::POS_FIRST};
    step    = as_sym;

    if (!char_term && !in_set) begin
      // Control characters, space and the colon are errors; wide codes are symbols.
      verdict.kind = is_ascii ? ltc_pkg::KIND_ERR : ltc_pkg::KIND_SYM;
      step         = verdict;
    end else begin
      unique case (pos_q)
        ltc_pkg::POS_DOT1: begin
          if (char_term) begin
            verdict.kind = ltc_pkg::KIND_DOT; step = verdict;
          end else if (is_dec) begin
            go.pos = ltc_pkg::POS_FLOAT6; step = go;
          end else if (is_dot) begin
            go.pos = ltc_pkg::POS_DOT2; step = go;
          end
        end
        ltc_pkg::POS_DOT2: begin
          if (is_dot) begin
            go.pos = ltc_pkg::POS_DOT2; step = go;
          end else if (char_term) begin
            verdict.kind = ltc_pkg::KIND_ERR; step = verdict;
          end
        end
        ltc_pkg::POS_DIGIT1: begin
          if (is_rdig) begin
            go.pos = ltc_pkg::POS_DIGIT2; step = go;
          end else if (is_dec) begin
            go.pos = ltc_pkg::POS_FLOAT1; step = go;
          end else if (is_dot) begin
            go.pos = ltc_pkg::POS_FLOAT5; step = go;
          end else begin
            step = as_sign;
          end
        end
        ltc_pkg::POS_DIGIT2: begin
          if (char_term) begin
            verdict.kind = ltc_pkg::KIND_INT; step = verdict;
          end else if (is_dot) begin
            go.pos = ltc_pkg::POS_DIGIT3; step = go;
          end else if (is_slash) begin
            go.pos = ltc_pkg::POS_RATIO1; step = go;
          end else if (is_rdig) begin
            go.pos = ltc_pkg::POS_DIGIT2; step = go;
          end else if (is_dec) begin
            go.pos = ltc_pkg::POS_FLOAT1; step = go;
          end else if (is_expo) begin
            go.pos = ltc_pkg::POS_EXP1; step = go;
          end
        end
        ltc_pkg::POS_DIGIT3: begin
          if (char_term) begin
            verdict.kind = ltc_pkg::KIND_DEC; step = verdict;
          end else if (is_dec) begin
            go.pos = ltc_pkg::POS_FLOAT4; step = go;
          end else if (is_expo) begin
            go.pos = ltc_pkg::POS_EXP3; step = go;
          end
        end
        ltc_pkg::POS_RATIO1: begin
          if (is_rdig) begin
            go.pos = ltc_pkg::POS_RATIO2; step = go;
          end
        end
        ltc_pkg::POS_RATIO2: begin
          if (char_term) begin
            verdict.kind = ltc_pkg::KIND_RATIO; step = verdict;
          end else if (is_rdig) begin
            go.pos = ltc_pkg::POS_RATIO2; step = go;
          end
        end
        ltc_pkg::POS_FLOAT1: begin
          if (is_dec) begin
            go.pos = ltc_pkg::POS_FLOAT1; step = go;
          end else if (is_expo) begin
            go.pos = ltc_pkg::POS_EXP1; step = go;
          end else if (is_dot) begin
            go.pos = ltc_pkg::POS_FLOAT3; step = go;
          end
        end
        ltc_pkg::POS_FLOAT3: begin
          if (is_expo) begin
            go.pos = ltc_pkg::POS_EXP1; step = go;
          end else if (is_dec) begin
            go.pos = ltc_pkg::POS_FLOAT4; step = go;
          end else if (char_term) begin
            verdict.kind = ltc_pkg::KIND_DEC; step = verdict;
          end
        end
        ltc_pkg::POS_FLOAT4: begin
          if (char_term) begin
            verdict.kind = kind_float; step = verdict;
          end else if (is_expo) begin
            go.pos = ltc_pkg::POS_EXP1; step = go;
          end else if (is_dec) begin
            go.pos = ltc_pkg::POS_FLOAT4; step = go;
          end
        end
        ltc_pkg::POS_FLOAT5: begin
          if (is_dec) begin
            go.pos = ltc_pkg::POS_FLOAT6; step = go;
          end
        end
        ltc_pkg::POS_FLOAT6: begin
          if (char_term) begin
            verdict.kind = kind_float; step = verdict;
          end else if (is_dec) begin
            go.pos = ltc_pkg::POS_FLOAT6; step = go;
          end else if (is_expo) begin
            go.pos = ltc_pkg::POS_EXP1; step = go;
          end
        end
        ltc_pkg::POS_EXP1: begin
          if (is_sign) begin
            go.pos = ltc_pkg::POS_EXP2; step = go;
          end else if (is_dec) begin
            go.pos = ltc_pkg::POS_EXP3; step = go;
          end else begin
            step = as_mark;
          end
        end
        ltc_pkg::POS_EXP2: begin
          if (is_dec) begin
            go.pos = ltc_pkg::POS_EXP3; step = go;
          end else begin
            step = as_sign;
          end
        end
        ltc_pkg::POS_EXP3: begin
          if (char_term) begin
            verdict.kind = kind_float; step = verdict;
          end else if (is_dec) begin
            go.pos = ltc_pkg::POS_EXP3; step = go;
          end
        end
        ltc_pkg::POS_POT: begin
          step = as_sym;
        end
        ltc_pkg::POS_POTSIGN: begin
          step = as_sign;
        end
        ltc_pkg::POS_POTMARK: begin
          step = as_mark;
        end
        default: begin
          // Start of a token. An empty token is an error.
          if (char_term) begin
            verdict.kind = ltc_pkg::KIND_ERR; step = verdict;
          end else if (is_sign) begin
            go.pos = ltc_pkg::POS_DIGIT1; step = go;
          end else if (is_rdig) begin
            go.pos = ltc_pkg::POS_DIGIT2; step = go;
          end else if (is_dec) begin
            go.pos = ltc_pkg::POS_FLOAT1; step = go;
          end else if (is_dot) begin
            go.pos = ltc_pkg::POS_DOT1; step = go;
          end
        end
      endcase
    end
  end

  assign result_kind = held_q ? hkind_q : step.kind;

  // A radix digit that is a letter spoils the decimal-only flag, but only
  // where the number grammar takes it as a digit.
  logic letter_digit;
  assign letter_digit = is_rdig && !is_dec
                     && (in_first || (pos_q == ltc_pkg::POS_DIGIT1)
                         || (pos_q == ltc_pkg::POS_DIGIT2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= ltc_pkg::POS_FIRST;
      first_q <= 1'b0;
      saw_q   <= 1'b0;
      dall_q  <= 1'b1;
      held_q  <= 1'b0;
      hkind_q <= ltc_pkg::KIND_INT;
    end else if (fire) begin
      if (char_term) begin
        pos_q   <= ltc_pkg::POS_FIRST;
        first_q <= 1'b0;
        saw_q   <= 1'b0;
        dall_q  <= 1'b1;
        held_q  <= 1'b0;
        hkind_q <= ltc_pkg::KIND_INT;
      end else if (!held_q) begin
        saw_q <= saw_q || is_rdig;
        if (in_first) begin
          first_q <= first_n;
        end
        if (letter_digit) begin
          dall_q <= 1'b0;
        end
        if (step.done) begin
          held_q  <= 1'b1;
          hkind_q <= step.kind;
        end else begin
          pos_q <= step.pos;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register. One kind per terminator.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire && char_term) begin
      out_vld_q <= 1'b1;
    end else if (kind_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && char_term) begin
      out_kind_q <= result_kind;
    end
  end

  assign kind_o.valid      = out_vld_q;
  assign kind_o.token_kind = out_kind_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // A terminator always leaves a kind in the result register.
  `ASSERT_CHECK(a_term_gives_result, clk_i, rst_ni, fire && char_term |=> out_vld_q)
  // After a terminator the next token starts clean.
  `ASSERT_CHECK(a_term_restarts, clk_i, rst_ni, fire && char_term |=> !held_q && (pos_q == ltc_pkg::POS_FIRST) && dall_q && !saw_q)
  // The input side only stalls on a waiting terminator.
  `ASSERT_NEVER(a_stall_cause, clk_i, rst_ni, !char_i.ready && !(char_vld_q && char_term && out_vld_q))

endmodule
